// File: src/bls_pkg.sv
// Shared types and constants for the bounded LIFO stack.
// Used by bls_core and bounded_lifo_stack; depends on nothing.
package bls_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = 7;
    localparam int WORD_W  = 32;
    localparam int DIST_W  = 6;
    localparam int CAP_W   = 7;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Register index taken from the byte address (4 bytes per register).
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        MODE_PUSH      = 2'd0,
        MODE_POP       = 2'd1,
        MODE_READ      = 2'd2,
        MODE_OVERWRITE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                     mode;
        logic signed [WORD_W-1:0]  value;
        logic [DIST_W-1:0]         distance;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        t_status                   status;
        logic [COUNT_W-1:0]        fill;
    } t_rsp;

endpackage

// File: src/bls_core.sv
// Stack engine: entry memory, entry counter and read-modify-write sequencing.
// Depends on bls_pkg.
module bls_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  bls_pkg::t_req              i_req,
    input  logic [bls_pkg::CAP_W-1:0]  i_cap,
    output logic                       o_rsp_valid,
    output bls_pkg::t_rsp              o_rsp
);

    logic signed [bls_pkg::WORD_W-1:0] r_mem [bls_pkg::DEPTH];
    logic signed [bls_pkg::WORD_W-1:0] r_q;

    logic [bls_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_done;
    bls_pkg::t_status            r_status, n_status;
    logic                        r_has_data, n_has_data;
    logic                        r_ovw, n_ovw;
    logic [bls_pkg::ADDR_W-1:0]  r_addr;
    logic signed [bls_pkg::WORD_W-1:0] r_value;

    logic [bls_pkg::COUNT_W-1:0] eff_cap;
    logic [bls_pkg::COUNT_W-1:0] dist_ext;
    logic [bls_pkg::COUNT_W-1:0] pos;
    logic [bls_pkg::ADDR_W-1:0]  addr;
    logic                        rd_en;
    logic                        push_wr;
    logic                        wr_en;
    logic [bls_pkg::ADDR_W-1:0]  wr_addr;
    logic signed [bls_pkg::WORD_W-1:0] wr_data;

    // Capacity saturates at the memory depth.
    assign eff_cap  = (bls_pkg::COUNT_W'(i_cap) > bls_pkg::COUNT_W'(bls_pkg::DEPTH))
                    ? bls_pkg::COUNT_W'(bls_pkg::DEPTH) : bls_pkg::COUNT_W'(i_cap);
    assign dist_ext = bls_pkg::COUNT_W'(i_req.distance);
    assign pos      = r_count - bls_pkg::COUNT_W'(1) - dist_ext;

    always_comb begin
        n_count    = r_count;
        n_status   = bls_pkg::ST_OK;
        n_has_data = 1'b0;
        n_ovw      = 1'b0;
        addr       = r_count[bls_pkg::ADDR_W-1:0];
        rd_en      = 1'b0;
        push_wr    = 1'b0;
        unique case (i_req.mode)
            bls_pkg::MODE_PUSH: begin
                if (r_count >= eff_cap) begin
                    n_status = bls_pkg::ST_FULL;
                end else begin
                    push_wr = i_acc;
                    n_count = r_count + bls_pkg::COUNT_W'(1);
                end
            end
            bls_pkg::MODE_POP: begin
                if (r_count == '0) begin
                    n_status = bls_pkg::ST_EMPTY;
                end else begin
                    n_count    = r_count - bls_pkg::COUNT_W'(1);
                    addr       = n_count[bls_pkg::ADDR_W-1:0];
                    rd_en      = i_acc;
                    n_has_data = 1'b1;
                end
            end
            bls_pkg::MODE_READ, bls_pkg::MODE_OVERWRITE: begin
                if (r_count == '0) begin
                    n_status = bls_pkg::ST_EMPTY;
                end else if (dist_ext >= r_count) begin
                    n_status = bls_pkg::ST_RANGE;
                end else begin
                    addr       = pos[bls_pkg::ADDR_W-1:0];
                    rd_en      = i_acc;
                    n_has_data = 1'b1;
                    n_ovw      = (i_req.mode == bls_pkg::MODE_OVERWRITE);
                end
            end
            default: begin
                n_status = bls_pkg::ST_OK;
            end
        endcase
    end

    // Single write port: push writes in the accept cycle, overwrite writes back
    // in the cycle after it, once the old word has been read.
    assign wr_en   = push_wr | (r_done & r_ovw);
    assign wr_addr = push_wr ? addr : r_addr;
    assign wr_data = push_wr ? i_req.value : r_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_ovw   <= 1'b0;
        end else begin
            r_done <= i_acc;
            if (i_acc) begin
                r_count <= n_count;
                r_ovw   <= n_ovw;
            end else begin
                r_ovw   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_status   <= n_status;
            r_has_data <= n_has_data;
            r_addr     <= addr;
            r_value    <= i_req.value;
        end
    end

    assign o_rsp_valid = r_done;
    assign o_rsp.data   = r_has_data ? r_q : '0;
    assign o_rsp.status = r_status;
    assign o_rsp.fill   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bls_pkg::COUNT_W'(bls_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> !r_done)
        else $error("request accepted while previous one in flight");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |=> r_done ##1 !r_done)
        else $error("result beat not exactly one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status != bls_pkg::ST_OK) |-> o_rsp.data == '0)
        else $error("error result carries data");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_acc |=> r_count == $past(r_count))
        else $error("entry count changed without a request");

endmodule

// File: src/bounded_lifo_stack.sv
// Top level of the bounded LIFO stack: command port, APB capacity register.
// Depends on bls_pkg and bls_core.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  request   | start && !busy        | i_mode, i_value_in, i_distance
//  result    | o_done (one cycle)    | o_data_out, o_status, o_fill_level
//  config    | psel&penable&pwrite   | paddr, pwdata, prdata (capacity @ 0x0)
//
// The accept cycle of a request issues the memory read (or the push write);
// the next cycle shows the result and writes back an overwrite. busy is high
// in that result cycle; the core's done register (r_done) sets it.
// Reset (synchronous, i_rst_n low) empties the stack and sets capacity to 64;
// memory contents are not cleared. Results cannot be stalled by the receiver.
module bounded_lifo_stack (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_mode,
    input  logic signed [31:0]               i_value_in,
    input  logic [5:0]                       i_distance,
    output logic                             o_done,
    output logic signed [31:0]               o_data_out,
    output logic [1:0]                       o_status,
    output logic [6:0]                       o_fill_level,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bls_pkg::PADDR_W-1:0]      paddr,
    input  logic [bls_pkg::APB_W-1:0]        pwdata,
    output logic [bls_pkg::APB_W-1:0]        prdata,
    output logic                             pready
);

    logic [bls_pkg::CAP_W-1:0] r_cap;
    logic                      acc;
    logic                      cfg_wr;
    bls_pkg::t_req             req;
    bls_pkg::t_rsp             rsp;
    logic                      rsp_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == bls_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bls_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[bls_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bls_pkg::REG_CAPACITY) ? bls_pkg::APB_W'(r_cap) : '0;

    assign acc          = start & ~busy;
    assign req.mode     = bls_pkg::t_mode'(i_mode);
    assign req.value    = i_value_in;
    assign req.distance = i_distance;

    bls_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_req       (req),
        .i_cap       (r_cap),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    assign busy         = rsp_valid;
    assign o_done       = rsp_valid;
    assign o_data_out   = rsp.data;
    assign o_status     = rsp.status;
    assign o_fill_level = rsp.fill;

endmodule
